[hdl/rlb_pkg.sv]
// Shared types and constants for the RGBA layer blend unit.
package rlb_pkg;

    // Q16 fixed point, 1.0 = 65536, values 0..65536 need 17 bits
    typedef logic [16:0] q_t;

    localparam q_t Q_ONE     = 17'h10000;
    localparam q_t Q_HALF    = 17'h08000;
    localparam q_t Q_QUARTER = 17'h04000;

    // Opacity saturation and divide-by-100 reciprocal (exact for x < 2^23)
    localparam logic [6:0]  OPACITY_MAX = 7'd100;
    localparam logic [23:0] RECIP_100   = 24'd10737419;

    // Configuration register indexes
    localparam logic CFG_OPACITY = 1'b0;
    localparam logic CFG_MODE    = 1'b1;

    typedef enum logic [3:0] {
        MODE_NORMAL     = 4'd0,
        MODE_MULTIPLY   = 4'd1,
        MODE_SCREEN     = 4'd2,
        MODE_OVERLAY    = 4'd3,
        MODE_DARKEN     = 4'd4,
        MODE_LIGHTEN    = 4'd5,
        MODE_DODGE      = 4'd6,
        MODE_BURN       = 4'd7,
        MODE_HARD_LIGHT = 4'd8,
        MODE_SOFT_LIGHT = 4'd9,
        MODE_DIFFERENCE = 4'd10,
        MODE_EXCLUSION  = 4'd11
    } blend_mode_t;

    // Per-channel data leaving the front end, carried alongside the root unit
    typedef struct packed {
        q_t          s;
        q_t          d;
        blend_mode_t mode;
        logic [17:0] b_simple;
        q_t          soft_lo;
        q_t          cub;
        q_t          dm;
        logic [32:0] div_num;
        q_t          div_den;
        logic [7:0]  dstb;
        q_t          sa;
        q_t          da;
        logic [7:0]  dsta;
    } sq_side_t;

endpackage

[hdl/rlb_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module rlb_div
    import rlb_pkg::*;
#(
    parameter int NUMW  = 33,
    parameter int DENW  = 17,
    parameter int SIDEW = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUMW-1:0]  num,
    input  logic [DENW-1:0]  den,
    input  logic [SIDEW-1:0] side_in,
    output logic             out_valid,
    output logic [NUMW-1:0]  quot,
    output logic [SIDEW-1:0] side_out
);

    logic [DENW-1:0]  rem_w  [NUMW+1];
    logic [NUMW-1:0]  num_w  [NUMW+1];
    logic [NUMW-1:0]  quo_w  [NUMW+1];
    logic [DENW-1:0]  den_w  [NUMW+1];
    logic [SIDEW-1:0] side_w [NUMW+1];
    logic             vld_w  [NUMW+1];

    assign rem_w[0]  = '0;
    assign num_w[0]  = num;
    assign quo_w[0]  = '0;
    assign den_w[0]  = den;
    assign side_w[0] = side_in;
    assign vld_w[0]  = in_valid;

    for (genvar k = 0; k < NUMW; k++)
    begin : g_stage
        logic [DENW:0]    trial;
        logic [DENW:0]    diff;
        logic             ge;
        logic [DENW-1:0]  rem_reg;
        logic [NUMW-1:0]  num_reg;
        logic [NUMW-1:0]  quo_reg;
        logic [DENW-1:0]  den_reg;
        logic [SIDEW-1:0] side_reg;
        logic             vld_reg;

        // shift in next numerator bit, trial subtract
        always_comb
        begin
            trial = {rem_w[k], num_w[k][NUMW-1]};
            diff  = trial - {1'b0, den_w[k]};
            ge    = (trial >= {1'b0, den_w[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_w[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
                num_reg  <= num_w[k] << 1;
                quo_reg  <= {quo_w[k][NUMW-2:0], ge};
                den_reg  <= den_w[k];
                side_reg <= side_w[k];
            end
        end

        assign rem_w[k+1]  = rem_reg;
        assign num_w[k+1]  = num_reg;
        assign quo_w[k+1]  = quo_reg;
        assign den_w[k+1]  = den_reg;
        assign side_w[k+1] = side_reg;
        assign vld_w[k+1]  = vld_reg;
    end

    assign out_valid = vld_w[NUMW];
    assign quot      = quo_w[NUMW];
    assign side_out  = side_w[NUMW];

endmodule

[hdl/rlb_sqrt.sv]
// Pipelined digit-by-digit integer square root of a 33-bit value, with sideband.
module rlb_sqrt
    import rlb_pkg::*;
#(
    parameter int SIDEW = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [32:0]      x,
    input  logic [SIDEW-1:0] side_in,
    output logic             out_valid,
    output q_t               root,
    output logic [SIDEW-1:0] side_out
);

    localparam int XW    = 33;
    localparam int STEPS = 17;

    logic [XW-1:0]    x_w    [STEPS+1];
    logic [XW-1:0]    res_w  [STEPS+1];
    logic [SIDEW-1:0] side_w [STEPS+1];
    logic             vld_w  [STEPS+1];

    assign x_w[0]    = x;
    assign res_w[0]  = '0;
    assign side_w[0] = side_in;
    assign vld_w[0]  = in_valid;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [XW-1:0] BIT = {{(XW-1){1'b0}}, 1'b1} << (2 * (STEPS - 1 - k));

        logic [XW:0]      sum;
        logic             ge;
        logic [XW-1:0]    x_reg;
        logic [XW-1:0]    res_reg;
        logic [SIDEW-1:0] side_reg;
        logic             vld_reg;

        always_comb
        begin
            sum = {1'b0, res_w[k]} + {1'b0, BIT};
            ge  = ({1'b0, x_w[k]} >= sum);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_w[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg    <= ge ? (x_w[k] - sum[XW-1:0]) : x_w[k];
                res_reg  <= ge ? ((res_w[k] >> 1) + BIT) : (res_w[k] >> 1);
                side_reg <= side_w[k];
            end
        end

        assign x_w[k+1]    = x_reg;
        assign res_w[k+1]  = res_reg;
        assign side_w[k+1] = side_reg;
        assign vld_w[k+1]  = vld_reg;
    end

    assign out_valid = vld_w[STEPS];
    assign root      = res_w[STEPS][16:0];
    assign side_out  = side_w[STEPS];

endmodule

[hdl/rlb_front.sv]
// Front end: byte to Q16, effective alpha, product-based blend modes, divider operands.
module rlb_front
    import rlb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] pixel,
    input  logic [6:0]  opacity,
    input  blend_mode_t mode,
    output logic        out_valid,
    output sq_side_t    side [3]
);

    // ceil(b * 65536 / 255) = 257 * b + (b != 0)
    function automatic q_t to_q(input logic [7:0] b);
        to_q = {1'b0, b, 8'h00} + {9'h000, b} + {16'h0000, (b != 8'h00)};
    endfunction

    localparam logic [21:0] FOUR_ONE = 22'h040000;

    // stage 1: conversion
    logic        vld1_reg;
    q_t          s1_reg [3];
    q_t          d1_reg [3];
    logic [7:0]  dstb1_reg [3];
    q_t          qsa1_reg;
    q_t          qda1_reg;
    logic [6:0]  op1_reg;
    blend_mode_t mode1_reg;
    logic [7:0]  dsta1_reg;

    // stage 2: products
    logic        vld2_reg;
    logic [33:0] psd2_reg [3];
    logic [33:0] pinv2_reg [3];
    logic [33:0] pkd2_reg [3];
    logic [33:0] pdd2_reg [3];
    logic [33:0] pdm2_reg [3];
    q_t          s2_reg [3];
    q_t          d2_reg [3];
    logic [7:0]  dstb2_reg [3];
    logic [23:0] alpha2_reg;
    q_t          qda2_reg;
    blend_mode_t mode2_reg;
    logic [7:0]  dsta2_reg;

    // stage 3: second products, simple modes
    logic        vld3_reg;
    logic [47:0] samul3_reg;
    logic [33:0] pkd3_reg [3];
    logic [21:0] pcub3_reg [3];
    logic [17:0] bsim3_reg [3];
    q_t          dm3_reg [3];
    logic [32:0] dnum3_reg [3];
    q_t          dden3_reg [3];
    q_t          s3_reg [3];
    q_t          d3_reg [3];
    logic [7:0]  dstb3_reg [3];
    q_t          qda3_reg;
    blend_mode_t mode3_reg;
    logic [7:0]  dsta3_reg;

    // stage 4: output side
    logic        vld4_reg;
    sq_side_t    side4_reg [3];

    logic [6:0]  op_sat;
    logic [16:0] k1 [3];
    logic [17:0] bsim_next [3];
    logic [32:0] dnum_next [3];
    q_t          dden_next [3];
    logic [21:0] pcub_next [3];
    logic [38:0] cub_prod [3];

    assign op_sat = (opacity > OPACITY_MAX) ? OPACITY_MAX : opacity;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    // combinational terms per channel
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            k1[i] = 17'({1'b0, Q_ONE} - {s1_reg[i], 1'b0});

            unique case (mode2_reg)
                MODE_MULTIPLY:   bsim_next[i] = psd2_reg[i][33:16];
                MODE_SCREEN:     bsim_next[i] = 18'(Q_ONE) - pinv2_reg[i][33:16];
                MODE_OVERLAY:    bsim_next[i] = (d2_reg[i] < Q_HALF) ? psd2_reg[i][32:15]
                                              : 18'(Q_ONE) - pinv2_reg[i][32:15];
                MODE_HARD_LIGHT: bsim_next[i] = (s2_reg[i] < Q_HALF) ? psd2_reg[i][32:15]
                                              : 18'(Q_ONE) - pinv2_reg[i][32:15];
                MODE_DARKEN:     bsim_next[i] = 18'((s2_reg[i] < d2_reg[i]) ? s2_reg[i]
                                                                         : d2_reg[i]);
                MODE_LIGHTEN:    bsim_next[i] = 18'((s2_reg[i] > d2_reg[i]) ? s2_reg[i]
                                                                         : d2_reg[i]);
                MODE_DIFFERENCE: bsim_next[i] = 18'((d2_reg[i] > s2_reg[i])
                                                    ? d2_reg[i] - s2_reg[i]
                                                    : s2_reg[i] - d2_reg[i]);
                MODE_EXCLUSION:  bsim_next[i] = 18'(d2_reg[i]) + 18'(s2_reg[i])
                                              - psd2_reg[i][32:15];
                default:         bsim_next[i] = 18'(s2_reg[i]);
            endcase

            // burn divides (1 - d) by s, dodge divides d by (1 - s)
            if (mode2_reg == MODE_BURN)
            begin
                dnum_next[i] = {Q_ONE - d2_reg[i], 16'h0000};
                dden_next[i] = s2_reg[i];
            end
            else
            begin
                dnum_next[i] = {d2_reg[i], 16'h0000};
                dden_next[i] = Q_ONE - s2_reg[i];
            end

            // soft light cubic: 16 d^2 + 4 - 12 d
            pcub_next[i] = 22'({pdd2_reg[i][32:16], 4'h0}) + FOUR_ONE
                         - 22'({d2_reg[i], 3'b000}) - 22'({d2_reg[i], 2'b00});

            cub_prod[i] = 39'(pcub3_reg[i]) * 39'(d3_reg[i]);
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_reg[i]    <= to_q(pixel[8*i +: 8]);
                d1_reg[i]    <= to_q(pixel[32 + 8*i +: 8]);
                dstb1_reg[i] <= pixel[32 + 8*i +: 8];

                psd2_reg[i]  <= 34'(s1_reg[i]) * 34'(d1_reg[i]);
                pinv2_reg[i] <= 34'(Q_ONE - s1_reg[i]) * 34'(Q_ONE - d1_reg[i]);
                pkd2_reg[i]  <= 34'(k1[i]) * 34'(d1_reg[i]);
                pdd2_reg[i]  <= 34'(d1_reg[i]) * 34'(d1_reg[i]);
                pdm2_reg[i]  <= 34'(d1_reg[i]) * 34'(qda1_reg);
                s2_reg[i]    <= s1_reg[i];
                d2_reg[i]    <= d1_reg[i];
                dstb2_reg[i] <= dstb1_reg[i];

                pkd3_reg[i]  <= 34'(pkd2_reg[i][32:16]) * 34'(Q_ONE - d2_reg[i]);
                pcub3_reg[i] <= pcub_next[i];
                bsim3_reg[i] <= bsim_next[i];
                dm3_reg[i]   <= pdm2_reg[i][32:16];
                dnum3_reg[i] <= dnum_next[i];
                dden3_reg[i] <= dden_next[i];
                s3_reg[i]    <= s2_reg[i];
                d3_reg[i]    <= d2_reg[i];
                dstb3_reg[i] <= dstb2_reg[i];

                side4_reg[i].s        <= s3_reg[i];
                side4_reg[i].d        <= d3_reg[i];
                side4_reg[i].mode     <= mode3_reg;
                side4_reg[i].b_simple <= bsim3_reg[i];
                side4_reg[i].soft_lo  <= d3_reg[i] - pkd3_reg[i][32:16];
                side4_reg[i].cub      <= cub_prod[i][32:16];
                side4_reg[i].dm       <= dm3_reg[i];
                side4_reg[i].div_num  <= dnum3_reg[i];
                side4_reg[i].div_den  <= dden3_reg[i];
                side4_reg[i].dstb     <= dstb3_reg[i];
                side4_reg[i].sa       <= samul3_reg[46:30];
                side4_reg[i].da       <= qda3_reg;
                side4_reg[i].dsta     <= dsta3_reg;
            end

            qsa1_reg   <= to_q(pixel[31:24]);
            qda1_reg   <= to_q(pixel[63:56]);
            op1_reg    <= op_sat;
            mode1_reg  <= mode;
            dsta1_reg  <= pixel[63:56];

            alpha2_reg <= 24'(qsa1_reg) * 24'(op1_reg);
            qda2_reg   <= qda1_reg;
            mode2_reg  <= mode1_reg;
            dsta2_reg  <= dsta1_reg;

            samul3_reg <= 48'(alpha2_reg) * 48'(RECIP_100);
            qda3_reg   <= qda2_reg;
            mode3_reg  <= mode2_reg;
            dsta3_reg  <= dsta2_reg;
        end
    end

    assign out_valid = vld4_reg;
    assign side      = side4_reg;

endmodule

[hdl/rgba_layer_blend_unit.sv]
// Top level of the RGBA layer blend unit: pipeline, compositing and output register.
//
//  channel | dir | width | content
//  s_*     | in  | 64    | src r,g,b,a then dst r,g,b,a, one pixel per request
//  m_*     | out | 32    | out r,g,b,a, one pixel per request
//  cfg_*   | in  | 7     | index 0 opacity percent, index 1 blend mode
//
// One pixel is accepted per clock unless m_tready stalls; it runs the 17-step root,
// the 33-bit dodge/burn divider and the 36-bit final divider, one bit per stage.
// rst_n clears every valid bit and sets opacity 100, mode normal; no clearing pass.
// A stall on m_tready freezes the whole pipeline; s_tready drops in the same cycle.
module rgba_layer_blend_unit
    import rlb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // src_red, src_green, src_blue, src_alpha,
                                   // dst_red, dst_green, dst_blue, dst_alpha
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    typedef struct packed {
        q_t          s;
        q_t          d;
        blend_mode_t mode;
        logic [17:0] b_simple;
        q_t          soft_lo;
        logic [17:0] soft_hi;
        q_t          dm;
        logic [7:0]  dstb;
        q_t          sa;
        q_t          oa_part;
        logic [7:0]  dsta;
    } mid_side_t;

    typedef struct packed {
        logic [17:0] b;
        q_t          sa;
        q_t          dm;
        q_t          oa;
        logic [7:0]  dstb;
        logic [7:0]  dsta;
    } c0_t;

    typedef struct packed {
        logic [34:0] prod_b;
        logic [33:0] prod_d;
        q_t          oa;
        logic [7:0]  dstb;
        logic [7:0]  dsta;
    } c1_t;

    typedef struct packed {
        logic        zero;
        q_t          oa;
        logic [7:0]  dstb;
        logic [7:0]  dsta;
    } fin_t;

    // Q16 to byte, floor(v * 255 / 65536) clamped to 255
    function automatic logic [7:0] to_byte(input logic [35:0] v);
        logic [24:0] m;
        m = {v[16:0], 8'h00} - {8'h00, v[16:0]};
        if ((|v[35:17]) || m[24])
            to_byte = 8'hFF;
        else
            to_byte = m[23:16];
    endfunction

    logic        en;
    logic [6:0]  opacity_reg;
    blend_mode_t mode_reg;

    logic        fe_vld;
    sq_side_t    fe_side [3];

    logic        sq_vld [3];
    q_t          sq_root [3];
    logic [$bits(sq_side_t)-1:0] sq_side_v [3];
    sq_side_t    sq_side [3];

    logic        m1_vld_reg;
    mid_side_t   m1_reg [3];
    logic [32:0] m1_num_reg [3];
    q_t          m1_den_reg [3];
    mid_side_t   m1_next [3];

    logic        d1_vld [3];
    logic [32:0] d1_quot [3];
    logic [$bits(mid_side_t)-1:0] d1_side_v [3];
    mid_side_t   d1_side [3];

    logic        c0_vld_reg;
    c0_t         c0_reg [3];
    c0_t         c0_next [3];
    logic        c1_vld_reg;
    c1_t         c1_reg [3];
    logic        c2_vld_reg;
    logic [35:0] c2_num_reg [3];
    q_t          c2_den_reg [3];
    fin_t        c2_fin_reg [3];

    logic        d2_vld [3];
    logic [35:0] d2_quot [3];
    logic [$bits(fin_t)-1:0] d2_side_v [3];
    fin_t        d2_side [3];

    logic        out_vld_reg;
    logic [31:0] out_data_reg;

    // global advance: hold everything while a result waits
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= OPACITY_MAX;
            mode_reg    <= MODE_NORMAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OPACITY: opacity_reg <= cfg_data;
                CFG_MODE:    mode_reg    <= blend_mode_t'(cfg_data[3:0]);
                default:     opacity_reg <= opacity_reg;
            endcase
        end
    end

    rlb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .pixel     (s_tdata),
        .opacity   (opacity_reg),
        .mode      (mode_reg),
        .out_valid (fe_vld),
        .side      (fe_side)
    );

    // per-channel square root for soft light
    for (genvar i = 0; i < 3; i++)
    begin : g_sqrt
        rlb_sqrt #(
            .SIDEW ($bits(sq_side_t))
        ) u_sqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (fe_vld),
            .x         ({fe_side[i].d, 16'h0000}),
            .side_in   (fe_side[i]),
            .out_valid (sq_vld[i]),
            .root      (sq_root[i]),
            .side_out  (sq_side_v[i])
        );
        assign sq_side[i] = sq_side_t'(sq_side_v[i]);
    end

    // soft light upper branch product and alpha product
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_t          dd_sel;
            q_t          dd;
            q_t          two_s_m1;
            logic [33:0] hp;
            logic [33:0] oap;
            dd_sel   = (sq_side[i].d < Q_QUARTER) ? sq_side[i].cub : sq_root[i];
            dd       = (dd_sel < sq_side[i].d) ? sq_side[i].d : dd_sel;
            two_s_m1 = 17'({sq_side[i].s, 1'b0} - {1'b0, Q_ONE});
            hp       = 34'(two_s_m1) * 34'(dd - sq_side[i].d);
            oap      = 34'(sq_side[i].da) * 34'(Q_ONE - sq_side[i].sa);

            m1_next[i].s        = sq_side[i].s;
            m1_next[i].d        = sq_side[i].d;
            m1_next[i].mode     = sq_side[i].mode;
            m1_next[i].b_simple = sq_side[i].b_simple;
            m1_next[i].soft_lo  = sq_side[i].soft_lo;
            m1_next[i].soft_hi  = hp[33:16];
            m1_next[i].dm       = sq_side[i].dm;
            m1_next[i].dstb     = sq_side[i].dstb;
            m1_next[i].sa       = sq_side[i].sa;
            m1_next[i].oa_part  = oap[32:16];
            m1_next[i].dsta     = sq_side[i].dsta;
        end
    end

    // blend mode selection and result alpha
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mid_side_t m;
            logic [17:0] b;
            logic [17:0] oa_sum;
            m = d1_side[i];
            unique case (m.mode)
                MODE_DODGE:
                    if (m.s >= Q_ONE)
                        b = 18'(Q_ONE);
                    else if (d1_quot[i] > 33'(Q_ONE))
                        b = 18'(Q_ONE);
                    else
                        b = d1_quot[i][17:0];
                MODE_BURN:
                    if (m.s == 17'd0)
                        b = 18'd0;
                    else if (d1_quot[i] > 33'(Q_ONE))
                        b = 18'd0;
                    else
                        b = 18'(Q_ONE) - d1_quot[i][17:0];
                MODE_SOFT_LIGHT:
                    b = (m.s < Q_HALF) ? 18'(m.soft_lo) : 18'(m.d) + m.soft_hi;
                default:
                    b = m.b_simple;
            endcase
            oa_sum = 18'(m.sa) + 18'(m.oa_part);

            c0_next[i].b    = b;
            c0_next[i].sa   = m.sa;
            c0_next[i].dm   = m.dm;
            c0_next[i].oa   = oa_sum[16:0];
            c0_next[i].dstb = m.dstb;
            c0_next[i].dsta = m.dsta;
        end
    end

    // per-channel dodge / burn divider
    for (genvar i = 0; i < 3; i++)
    begin : g_div1
        rlb_div #(
            .NUMW  (33),
            .DENW  (17),
            .SIDEW ($bits(mid_side_t))
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (m1_vld_reg),
            .num       (m1_num_reg[i]),
            .den       (m1_den_reg[i]),
            .side_in   (m1_reg[i]),
            .out_valid (d1_vld[i]),
            .quot      (d1_quot[i]),
            .side_out  (d1_side_v[i])
        );
        assign d1_side[i] = mid_side_t'(d1_side_v[i]);
    end

    // per-channel divide by result alpha
    for (genvar i = 0; i < 3; i++)
    begin : g_div2
        rlb_div #(
            .NUMW  (36),
            .DENW  (17),
            .SIDEW ($bits(fin_t))
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c2_vld_reg),
            .num       (c2_num_reg[i]),
            .den       (c2_den_reg[i]),
            .side_in   (c2_fin_reg[i]),
            .out_valid (d2_vld[i]),
            .quot      (d2_quot[i]),
            .side_out  (d2_side_v[i])
        );
        assign d2_side[i] = fin_t'(d2_side_v[i]);
    end

    // valid chain of the middle and back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg  <= 1'b0;
            c0_vld_reg  <= 1'b0;
            c1_vld_reg  <= 1'b0;
            c2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg  <= sq_vld[0] & sq_vld[1] & sq_vld[2];
            c0_vld_reg  <= d1_vld[0] & d1_vld[1] & d1_vld[2];
            c1_vld_reg  <= c0_vld_reg;
            c2_vld_reg  <= c1_vld_reg;
            out_vld_reg <= d2_vld[0] & d2_vld[1] & d2_vld[2];
        end
    end

    // payload of the middle and back stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_reg[i]     <= m1_next[i];
                m1_num_reg[i] <= sq_side[i].div_num;
                m1_den_reg[i] <= sq_side[i].div_den;

                c0_reg[i]     <= c0_next[i];

                c1_reg[i].prod_b <= 35'(c0_reg[i].b) * 35'(c0_reg[i].sa);
                c1_reg[i].prod_d <= 34'(c0_reg[i].dm) * 34'(Q_ONE - c0_reg[i].sa);
                c1_reg[i].oa     <= c0_reg[i].oa;
                c1_reg[i].dstb   <= c0_reg[i].dstb;
                c1_reg[i].dsta   <= c0_reg[i].dsta;

                c2_num_reg[i]      <= 36'(c1_reg[i].prod_b) + 36'(c1_reg[i].prod_d);
                c2_den_reg[i]      <= (c1_reg[i].oa == 17'd0) ? 17'd1 : c1_reg[i].oa;
                c2_fin_reg[i].zero <= (c1_reg[i].oa == 17'd0);
                c2_fin_reg[i].oa   <= c1_reg[i].oa;
                c2_fin_reg[i].dstb <= c1_reg[i].dstb;
                c2_fin_reg[i].dsta <= c1_reg[i].dsta;

                out_data_reg[8*i +: 8] <= d2_side[i].zero ? d2_side[i].dstb
                                                          : to_byte(d2_quot[i]);
            end
            out_data_reg[31:24] <= d2_side[0].zero ? d2_side[0].dsta
                                                   : to_byte(36'(d2_side[0].oa));
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

[hdl/rlb_checker.sv]
// Port-level checker for the RGBA layer blend unit, bound to the top level.
module rlb_port_props (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // input side opens exactly when the output register can move
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output register state");

    // reset empties the output register
    a_reset_clears_output: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("m_tvalid high during reset");

    // a stalled result stays offered
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind rgba_layer_blend_unit rlb_port_props u_rlb_port_props (.*);
